// ----- hw/rtl/ggc_pkg.sv -----
// Package for the greedy graph coloring block.
// Holds the field widths, the opcode, ordering mode and register index codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ggc_pkg;

  localparam int unsigned NODE_W     = 6;
  localparam int unsigned COLOR_W    = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned EDGE_W     = 2 * NODE_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // opcodes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // ordering modes
  localparam logic MODE_MCS    = 1'b0;
  localparam logic MODE_DEGREE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_EV,
    S_ERR_OUT,
    S_MCS_SEED,
    S_POP_RD,
    S_POP_A,
    S_POP_B,
    S_NB_RD,
    S_NB_EV,
    S_RS_RD,
    S_RS_A,
    S_RS_B,
    S_RS_C,
    S_ADD_RD,
    S_ADD_WR,
    S_DEG_CLR,
    S_DEG_ERD,
    S_DEG_EV,
    S_DEG_A,
    S_DEG_BRD,
    S_DEG_B,
    S_SEL_RD,
    S_SEL_EV,
    S_COL_VRD,
    S_COL_V,
    S_COL_ERD,
    S_COL_EV,
    S_COL_CU,
    S_COL_PICK,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ggc_if.sv -----
// Handshake channels of the greedy graph coloring block: input, result and register write.
// Depends on ggc_pkg.
`default_nettype none

interface ggc_in_if import ggc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [NODE_W-1:0] end_a;
  logic [NODE_W-1:0] end_b;

  modport source (output valid, op, end_a, end_b, input ready);
  modport sink   (input valid, op, end_a, end_b, output ready);
endinterface

interface ggc_out_if import ggc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NODE_W-1:0]  node;
  logic [COLOR_W-1:0] color;
  logic [COUNT_W-1:0] color_count;
  logic               error;
  logic               last;

  modport source (output valid, node, color, color_count, error, last, input ready);
  modport sink   (input valid, node, color, color_count, error, last, output ready);
endinterface

interface ggc_cfg_if import ggc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ggc_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module ggc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_graph_coloring.sv -----
// Greedy graph coloring: top level with the edge store, the ordering and coloring sequencer.
// Depends on ggc_pkg, ggc_if and ggc_ram.
//
//   channel | dir | word                                   | accepted when
//   in_i    | in  | op, end_a, end_b                       | valid & ready
//   out_o   | out | node, color, color_count, error, last  | valid & ready
//   cfg_i   | in  | index, data                            | valid & ready (ready always high)
//
// a run first checks the endpoints of every stored edge against the node count.
// search order: per node a pop from the highest bucket, then a walk over all edges that
// adds each new neighbor and raises each touched one; degree order: a degree count over
// all edges, then a scan of all nodes per pick; coloring walks all edges per node, then emits.
// no clearing pass after reset: per-node flags live in flip-flops.
// a pending result word does not block edge loads; out_o stalls only hold the sequencer.
`default_nettype none

module greedy_graph_coloring import ggc_pkg::*; #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ggc_in_if.sink    in_i,
  ggc_out_if.source out_o,
  ggc_cfg_if.sink   cfg_i
);

  localparam int unsigned NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNW = NAW + 1;
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
  localparam int unsigned DGW = $clog2(2 * MAX_EDGES + 1);
  localparam int unsigned SAW = 2 * NAW;

  state_e state_q, state_d;

  logic                  order_mode_q, order_mode_d;
  logic [CFG_DATA_W-1:0] node_count_q, node_count_d;
  logic [ETW-1:0]        edge_total_q, edge_total_d;
  logic                  bad_q, bad_d;
  logic                  mode_q, mode_d;
  logic [CNW-1:0]        n_q, n_d;
  logic [ETW-1:0]        k_q, k_d;
  logic [CNW-1:0]        it_q, it_d;
  logic [CNW-1:0]        v_q, v_d;
  logic [NAW-1:0]        top_q, top_d;
  logic [MAX_NODES-1:0]  visited_q, visited_d;
  logic [MAX_NODES-1:0]  touched_q, touched_d;
  logic [MAX_NODES-1:0]  nonempty_q, nonempty_d;
  logic [MAX_NODES-1:0]  colored_q, colored_d;
  logic [MAX_NODES-1:0]  taken_q, taken_d;
  logic [MAX_NODES-1:0]  used_q, used_d;
  logic [NAW-1:0]        cur_v_q, cur_v_d;
  logic [NAW-1:0]        nb_u_q, nb_u_d;
  logic [NAW-1:0]        w_q, w_d;
  logic [NAW-1:0]        idx_q, idx_d;
  logic [CNW-1:0]        f_q, f_d;
  logic [NAW-1:0]        add_w_q, add_w_d;
  logic [NAW-1:0]        add_u_q, add_u_d;
  logic [NAW-1:0]        ea_q, ea_d;
  logic [NAW-1:0]        eb_q, eb_d;
  logic [NAW-1:0]        best_q, best_d;
  logic [DGW-1:0]        bestd_q, bestd_d;
  logic                  found_q, found_d;
  logic [CNW-1:0]        count_q, count_d;

  logic               out_valid_q, out_valid_d;
  logic [NODE_W-1:0]  out_node_q, out_node_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_error_q, out_error_d;
  logic               out_last_q, out_last_d;

  // memory ports
  logic              edge_we;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rdata;
  logic              nodew_we;
  logic [NAW-1:0]    nodew_waddr, nodew_raddr;
  logic [2*NAW-1:0]  nodew_wdata, nodew_rdata;
  logic              fill_we;
  logic [NAW-1:0]    fill_waddr, fill_raddr;
  logic [CNW-1:0]    fill_wdata, fill_rdata;
  logic              slots_we;
  logic [SAW-1:0]    slots_waddr, slots_raddr;
  logic [NAW-1:0]    slots_wdata, slots_rdata;
  logic              color_we;
  logic [NAW-1:0]    color_waddr, color_raddr;
  logic [NAW-1:0]    color_wdata, color_rdata;
  logic              visit_we;
  logic [NAW-1:0]    visit_waddr, visit_raddr;
  logic [NAW-1:0]    visit_wdata, visit_rdata;
  logic              deg_we;
  logic [NAW-1:0]    deg_waddr, deg_raddr;
  logic [DGW-1:0]    deg_wdata, deg_rdata;

  ggc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  // per node: weight and slot inside its bucket
  ggc_ram #(.WIDTH(2 * NAW), .DEPTH(MAX_NODES)) u_nodew_ram (
    .clk_i, .we_i(nodew_we), .waddr_i(nodew_waddr), .wdata_i(nodew_wdata),
    .raddr_i(nodew_raddr), .rdata_o(nodew_rdata)
  );
  ggc_ram #(.WIDTH(CNW), .DEPTH(MAX_NODES)) u_fill_ram (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_rdata)
  );
  ggc_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES * MAX_NODES)) u_slots_ram (
    .clk_i, .we_i(slots_we), .waddr_i(slots_waddr), .wdata_i(slots_wdata),
    .raddr_i(slots_raddr), .rdata_o(slots_rdata)
  );
  ggc_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_color_ram (
    .clk_i, .we_i(color_we), .waddr_i(color_waddr), .wdata_i(color_wdata),
    .raddr_i(color_raddr), .rdata_o(color_rdata)
  );
  ggc_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_visit_ram (
    .clk_i, .we_i(visit_we), .waddr_i(visit_waddr), .wdata_i(visit_wdata),
    .raddr_i(visit_raddr), .rdata_o(visit_rdata)
  );
  ggc_ram #(.WIDTH(DGW), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  // shared decode
  logic [NODE_W-1:0] edge_a, edge_b;
  logic              edge_oob;
  logic              nb_hit;
  logic [NAW-1:0]    nb_node;
  logic              out_free;
  logic              k_end, v_end, it_end, it_last;
  logic [CNW-1:0]    n_clamp;
  logic [CNW-1:0]    fill_rs, fill_add;
  logic [NAW-1:0]    pop_w;
  logic [NAW-1:0]    pop_v;
  logic [CNW-1:0]    pop_f;
  logic [CNW-1:0]    pop_f_dec;
  logic [NAW-1:0]    rs_w, rs_i;
  logic              rs_sat;

  assign edge_a   = edge_rdata[NODE_W-1:0];
  assign edge_b   = edge_rdata[EDGE_W-1:NODE_W];
  assign edge_oob = ({1'b0, edge_a} >= (NODE_W + 1)'(n_q)) ||
                    ({1'b0, edge_b} >= (NODE_W + 1)'(n_q));
  assign nb_hit   = (edge_a == NODE_W'(cur_v_q)) || (edge_b == NODE_W'(cur_v_q));
  assign nb_node  = (edge_a == NODE_W'(cur_v_q)) ? edge_b[NAW-1:0] : edge_a[NAW-1:0];
  assign out_free = !out_valid_q || out_o.ready;
  assign k_end    = (k_q == edge_total_q);
  assign v_end    = (v_q == n_q);
  assign it_end   = (it_q == n_q);
  assign it_last  = (CNW'(it_q + 1'b1) == n_q);
  assign fill_rs  = nonempty_q[w_q] ? fill_rdata : '0;
  assign fill_add = nonempty_q[add_w_q] ? fill_rdata : '0;
  assign pop_w    = top_q;
  assign pop_v    = slots_rdata;
  assign pop_f    = fill_rdata;
  assign pop_f_dec = CNW'(pop_f - 1'b1);
  assign rs_w     = nodew_rdata[2*NAW-1:NAW];
  assign rs_i     = nodew_rdata[NAW-1:0];
  assign rs_sat   = (CNW'(rs_w) + 1'b1) >= CNW'(MAX_NODES);

  always_comb begin
    if (node_count_q == '0) begin
      n_clamp = CNW'(1);
    end else if (node_count_q > CFG_DATA_W'(MAX_NODES)) begin
      n_clamp = CNW'(MAX_NODES);
    end else begin
      n_clamp = CNW'(node_count_q);
    end
  end

  // lowest unvisited node below n
  logic           seed_found;
  logic [NAW-1:0] seed_u;
  always_comb begin
    seed_found = 1'b0;
    seed_u     = '0;
    for (int j = MAX_NODES - 1; j >= 0; j--) begin
      if (!visited_q[j] && (CNW'(j) < n_q)) begin
        seed_found = 1'b1;
        seed_u     = NAW'(j);
      end
    end
  end

  // highest non-empty bucket other than the one being emptied
  logic [NAW-1:0] top_hi;
  always_comb begin
    top_hi = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      if (nonempty_q[j] && (NAW'(j) != top_q)) begin
        top_hi = NAW'(j);
      end
    end
  end

  // smallest color no colored neighbor uses
  logic [NAW-1:0] pick_c;
  always_comb begin
    pick_c = NAW'(MAX_NODES - 1);
    for (int j = MAX_NODES - 2; j >= 0; j--) begin
      if (!used_q[j]) begin
        pick_c = NAW'(j);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.op == OP_RUN) begin
          state_d = bad_q ? S_ERR_OUT : S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        if (k_end) begin
          state_d = (mode_q == MODE_MCS) ? S_MCS_SEED : S_DEG_CLR;
        end else begin
          state_d = S_CHK_EV;
        end
      end
      S_CHK_EV:   state_d = edge_oob ? S_ERR_OUT : S_CHK_RD;
      S_ERR_OUT:  if (out_free) state_d = S_IDLE;
      S_MCS_SEED: begin
        if (nonempty_q[top_q] || seed_found) begin
          state_d = S_POP_RD;
        end else begin
          state_d = S_COL_VRD;
        end
      end
      S_POP_RD:   state_d = S_POP_A;
      S_POP_A:    state_d = (pop_f > CNW'(1)) ? S_POP_B : S_NB_RD;
      S_POP_B:    state_d = S_NB_RD;
      S_NB_RD: begin
        if (k_end) begin
          state_d = it_last ? S_COL_VRD : S_MCS_SEED;
        end else begin
          state_d = S_NB_EV;
        end
      end
      S_NB_EV: begin
        if (!nb_hit || visited_q[nb_node]) begin
          state_d = S_NB_RD;
        end else if (!touched_q[nb_node]) begin
          state_d = S_ADD_RD;
        end else begin
          state_d = S_RS_RD;
        end
      end
      S_RS_RD:    state_d = S_RS_A;
      S_RS_A:     state_d = rs_sat ? S_NB_RD : S_RS_B;
      S_RS_B: begin
        if (fill_rs == '0 || CNW'(idx_q) >= fill_rs) begin
          state_d = S_NB_RD;
        end else begin
          state_d = S_RS_C;
        end
      end
      S_RS_C:     state_d = S_ADD_RD;
      S_ADD_RD:   state_d = S_ADD_WR;
      S_ADD_WR:   state_d = S_NB_RD;
      S_DEG_CLR:  if (v_end) state_d = S_DEG_ERD;
      S_DEG_ERD:  state_d = k_end ? S_SEL_RD : S_DEG_EV;
      S_DEG_EV:   state_d = S_DEG_A;
      S_DEG_A:    state_d = S_DEG_BRD;
      S_DEG_BRD:  state_d = S_DEG_B;
      S_DEG_B:    state_d = S_DEG_ERD;
      S_SEL_RD: begin
        if (v_end) begin
          state_d = it_last ? S_COL_VRD : S_SEL_RD;
        end else begin
          state_d = S_SEL_EV;
        end
      end
      S_SEL_EV:   state_d = S_SEL_RD;
      S_COL_VRD:  state_d = it_end ? S_EMIT_RD : S_COL_V;
      S_COL_V:    state_d = S_COL_ERD;
      S_COL_ERD:  state_d = k_end ? S_COL_PICK : S_COL_EV;
      S_COL_EV:   state_d = (nb_hit && colored_q[nb_node]) ? S_COL_CU : S_COL_ERD;
      S_COL_CU:   state_d = S_COL_ERD;
      S_COL_PICK: state_d = S_COL_VRD;
      S_EMIT_RD:  state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_free) begin
          state_d = (CNW'(v_q + 1'b1) == n_q) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    order_mode_d = order_mode_q;
    node_count_d = node_count_q;
    edge_total_d = edge_total_q;
    bad_d        = bad_q;
    mode_d       = mode_q;
    n_d          = n_q;
    k_d          = k_q;
    it_d         = it_q;
    v_d          = v_q;
    top_d        = top_q;
    visited_d    = visited_q;
    touched_d    = touched_q;
    nonempty_d   = nonempty_q;
    colored_d    = colored_q;
    taken_d      = taken_q;
    used_d       = used_q;
    cur_v_d      = cur_v_q;
    nb_u_d       = nb_u_q;
    w_d          = w_q;
    idx_d        = idx_q;
    f_d          = f_q;
    add_w_d      = add_w_q;
    add_u_d      = add_u_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    best_d       = best_q;
    bestd_d      = bestd_q;
    found_d      = found_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_node_d   = out_node_q;
    out_color_d  = out_color_q;
    out_count_d  = out_count_q;
    out_error_d  = out_error_q;
    out_last_d   = out_last_q;

    in_i.ready   = (state_q == S_IDLE);

    edge_we      = 1'b0;
    edge_waddr   = edge_total_q[EAW-1:0];
    edge_wdata   = {in_i.end_b, in_i.end_a};
    edge_raddr   = k_q[EAW-1:0];
    nodew_we     = 1'b0;
    nodew_waddr  = add_u_q;
    nodew_wdata  = '0;
    nodew_raddr  = nb_u_q;
    fill_we      = 1'b0;
    fill_waddr   = top_q;
    fill_wdata   = '0;
    fill_raddr   = top_q;
    slots_we     = 1'b0;
    slots_waddr  = '0;
    slots_wdata  = '0;
    slots_raddr  = {top_q, NAW'(0)};
    color_we     = 1'b0;
    color_waddr  = cur_v_q;
    color_wdata  = pick_c;
    color_raddr  = v_q[NAW-1:0];
    visit_we     = 1'b0;
    visit_waddr  = it_q[NAW-1:0];
    visit_wdata  = '0;
    visit_raddr  = it_q[NAW-1:0];
    deg_we       = 1'b0;
    deg_waddr    = v_q[NAW-1:0];
    deg_wdata    = '0;
    deg_raddr    = v_q[NAW-1:0];

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ORDER_MODE: order_mode_d = cfg_i.data[0];
        REG_NODE_COUNT: node_count_d = cfg_i.data;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == OP_LOAD) begin
            if (edge_total_q == ETW'(MAX_EDGES)) begin
              bad_d = 1'b1;
            end else begin
              edge_we      = 1'b1;
              edge_total_d = ETW'(edge_total_q + 1'b1);
            end
          end else begin
            n_d    = n_clamp;
            mode_d = order_mode_q;
            k_d    = '0;
          end
        end
      end
      S_CHK_RD: begin
        if (k_end) begin
          visited_d  = '0;
          touched_d  = '0;
          nonempty_d = '0;
          top_d      = '0;
          it_d       = '0;
          v_d        = '0;
        end
      end
      S_CHK_EV: k_d = ETW'(k_q + 1'b1);
      S_ERR_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_node_d   = '0;
          out_color_d  = '0;
          out_count_d  = '0;
          out_error_d  = 1'b1;
          out_last_d   = 1'b1;
          edge_total_d = '0;
          bad_d        = 1'b0;
        end
      end
      S_MCS_SEED: begin
        if (!nonempty_q[top_q]) begin
          if (seed_found) begin
            // all buckets empty: start a new component in bucket zero
            top_d               = '0;
            nodew_we            = 1'b1;
            nodew_waddr         = seed_u;
            nodew_wdata         = '0;
            touched_d[seed_u]   = 1'b1;
            slots_we            = 1'b1;
            slots_waddr         = '0;
            slots_wdata         = seed_u;
            fill_we             = 1'b1;
            fill_waddr          = '0;
            fill_wdata          = CNW'(1);
            nonempty_d[0]       = 1'b1;
          end else begin
            colored_d = '0;
            count_d   = '0;
            it_d      = '0;
          end
        end
      end
      S_POP_RD: begin
        fill_raddr  = top_q;
        slots_raddr = {top_q, NAW'(0)};
      end
      S_POP_A: begin
        cur_v_d          = pop_v;
        visited_d[pop_v] = 1'b1;
        visit_we         = 1'b1;
        visit_wdata      = pop_v;
        fill_we          = 1'b1;
        fill_waddr       = pop_w;
        fill_wdata       = pop_f_dec;
        f_d              = pop_f;
        k_d              = '0;
        if (pop_f_dec == '0) begin
          nonempty_d[pop_w] = 1'b0;
          top_d             = top_hi;
        end else begin
          // last entry of the bucket moves to the front
          slots_raddr = {pop_w, pop_f_dec[NAW-1:0]};
        end
      end
      S_POP_B: begin
        nodew_we    = 1'b1;
        nodew_waddr = slots_rdata;
        nodew_wdata = {top_q, NAW'(0)};
        slots_we    = 1'b1;
        slots_waddr = {top_q, NAW'(0)};
        slots_wdata = slots_rdata;
      end
      S_NB_RD: begin
        if (k_end) begin
          it_d = CNW'(it_q + 1'b1);
          if (it_last) begin
            colored_d = '0;
            count_d   = '0;
            it_d      = '0;
          end
        end
      end
      S_NB_EV: begin
        k_d     = ETW'(k_q + 1'b1);
        nb_u_d  = nb_node;
        add_u_d = nb_node;
        add_w_d = NAW'(1);
      end
      S_RS_RD: nodew_raddr = nb_u_q;
      S_RS_A: begin
        w_d        = rs_w;
        idx_d      = rs_i;
        fill_raddr = rs_w;
      end
      S_RS_B: begin
        f_d         = fill_rs;
        slots_raddr = {w_q, NAW'(fill_rs - 1'b1)};
      end
      S_RS_C: begin
        // swap-remove: last entry of the bucket takes the raised node's slot
        nodew_we      = 1'b1;
        nodew_waddr   = slots_rdata;
        nodew_wdata   = {w_q, idx_q};
        slots_we      = 1'b1;
        slots_waddr   = {w_q, idx_q};
        slots_wdata   = slots_rdata;
        fill_we       = 1'b1;
        fill_waddr    = w_q;
        fill_wdata    = CNW'(f_q - 1'b1);
        nonempty_d[w_q] = (f_q != CNW'(1));
        add_w_d       = NAW'(w_q + 1'b1);
        add_u_d       = nb_u_q;
      end
      S_ADD_RD: fill_raddr = add_w_q;
      S_ADD_WR: begin
        nodew_we             = 1'b1;
        nodew_waddr          = add_u_q;
        nodew_wdata          = {add_w_q, fill_add[NAW-1:0]};
        slots_we             = 1'b1;
        slots_waddr          = {add_w_q, fill_add[NAW-1:0]};
        slots_wdata          = add_u_q;
        fill_we              = 1'b1;
        fill_waddr           = add_w_q;
        fill_wdata           = CNW'(fill_add + 1'b1);
        nonempty_d[add_w_q]  = 1'b1;
        touched_d[add_u_q]   = 1'b1;
        if (top_q < add_w_q) begin
          top_d = add_w_q;
        end
      end
      S_DEG_CLR: begin
        if (v_end) begin
          k_d = '0;
        end else begin
          deg_we    = 1'b1;
          deg_waddr = v_q[NAW-1:0];
          deg_wdata = '0;
          v_d       = CNW'(v_q + 1'b1);
        end
      end
      S_DEG_ERD: begin
        if (k_end) begin
          it_d    = '0;
          v_d     = '0;
          taken_d = '0;
          found_d = 1'b0;
        end
      end
      S_DEG_EV: begin
        ea_d      = edge_a[NAW-1:0];
        eb_d      = edge_b[NAW-1:0];
        deg_raddr = edge_a[NAW-1:0];
        k_d       = ETW'(k_q + 1'b1);
      end
      S_DEG_A: begin
        deg_we    = 1'b1;
        deg_waddr = ea_q;
        deg_wdata = DGW'(deg_rdata + 1'b1);
      end
      S_DEG_BRD: deg_raddr = eb_q;
      S_DEG_B: begin
        deg_we    = 1'b1;
        deg_waddr = eb_q;
        deg_wdata = DGW'(deg_rdata + 1'b1);
      end
      S_SEL_RD: begin
        if (v_end) begin
          taken_d[best_q] = 1'b1;
          visit_we        = 1'b1;
          visit_wdata     = best_q;
          it_d            = CNW'(it_q + 1'b1);
          v_d             = '0;
          found_d         = 1'b0;
          if (it_last) begin
            colored_d = '0;
            count_d   = '0;
            it_d      = '0;
          end
        end
      end
      S_SEL_EV: begin
        // strict compare keeps the lower index on equal degree
        if (!taken_q[v_q[NAW-1:0]] && (!found_q || deg_rdata > bestd_q)) begin
          best_d  = v_q[NAW-1:0];
          bestd_d = deg_rdata;
          found_d = 1'b1;
        end
        v_d = CNW'(v_q + 1'b1);
      end
      S_COL_VRD: begin
        if (it_end) begin
          v_d = '0;
        end
      end
      S_COL_V: begin
        cur_v_d = visit_rdata;
        used_d  = '0;
        k_d     = '0;
      end
      S_COL_ERD: ;
      S_COL_EV: begin
        k_d         = ETW'(k_q + 1'b1);
        color_raddr = nb_node;
      end
      S_COL_CU: used_d[color_rdata] = 1'b1;
      S_COL_PICK: begin
        color_we           = 1'b1;
        color_waddr        = cur_v_q;
        color_wdata        = pick_c;
        colored_d[cur_v_q] = 1'b1;
        if (CNW'(pick_c) + 1'b1 > count_q) begin
          count_d = CNW'(pick_c) + 1'b1;
        end
        it_d = CNW'(it_q + 1'b1);
      end
      S_EMIT_RD: color_raddr = v_q[NAW-1:0];
      S_EMIT_OUT: begin
        color_raddr = v_q[NAW-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_node_d  = NODE_W'(v_q);
          out_color_d = colored_q[v_q[NAW-1:0]] ? COLOR_W'(color_rdata) : '0;
          out_count_d = COUNT_W'(count_q);
          out_error_d = 1'b0;
          out_last_d  = (CNW'(v_q + 1'b1) == n_q);
          v_d         = CNW'(v_q + 1'b1);
          if (CNW'(v_q + 1'b1) == n_q) begin
            edge_total_d = '0;
            bad_d        = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.node        = out_node_q;
  assign out_o.color       = out_color_q;
  assign out_o.color_count = out_count_q;
  assign out_o.error       = out_error_q;
  assign out_o.last        = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      order_mode_q <= MODE_MCS;
      node_count_q <= CFG_DATA_W'(64);
      edge_total_q <= '0;
      bad_q        <= 1'b0;
      mode_q       <= MODE_MCS;
      n_q          <= '0;
      k_q          <= '0;
      it_q         <= '0;
      v_q          <= '0;
      top_q        <= '0;
      visited_q    <= '0;
      touched_q    <= '0;
      nonempty_q   <= '0;
      colored_q    <= '0;
      taken_q      <= '0;
      used_q       <= '0;
      found_q      <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      order_mode_q <= order_mode_d;
      node_count_q <= node_count_d;
      edge_total_q <= edge_total_d;
      bad_q        <= bad_d;
      mode_q       <= mode_d;
      n_q          <= n_d;
      k_q          <= k_d;
      it_q         <= it_d;
      v_q          <= v_d;
      top_q        <= top_d;
      visited_q    <= visited_d;
      touched_q    <= touched_d;
      nonempty_q   <= nonempty_d;
      colored_q    <= colored_d;
      taken_q      <= taken_d;
      used_q       <= used_d;
      found_q      <= found_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_v_q     <= cur_v_d;
    nb_u_q      <= nb_u_d;
    w_q         <= w_d;
    idx_q       <= idx_d;
    f_q         <= f_d;
    add_w_q     <= add_w_d;
    add_u_q     <= add_u_d;
    ea_q        <= ea_d;
    eb_q        <= eb_d;
    best_q      <= best_d;
    bestd_q     <= bestd_d;
    out_node_q  <= out_node_d;
    out_color_q <= out_color_d;
    out_count_q <= out_count_d;
    out_error_q <= out_error_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ggc_checker.sv -----
// Port-level checks for the greedy graph coloring block, bound to the top level.
// Depends on ggc_pkg and the top level greedy_graph_coloring.
`default_nettype none

module ggc_checker import ggc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [NODE_W-1:0]  out_node_i,
  input wire logic [COLOR_W-1:0] out_color_i,
  input wire logic [COUNT_W-1:0] out_count_i,
  input wire logic               out_error_i,
  input wire logic               out_last_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_node_i) &&
    $stable(out_color_i) && $stable(out_count_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // the error word closes its run and has all other fields zero
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_last_i && out_node_i == '0 &&
    out_color_i == '0 && out_count_i == '0)
    else $error("malformed error word");

  // a reported color lies below the color count
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_error_i |-> out_count_i != '0 &&
    {1'b0, out_color_i} < out_count_i)
    else $error("color outside color count");

  // no new input while a run is still emitting
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken during emission");

endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_node_i  (out_o.node),
  .out_color_i (out_o.color),
  .out_count_i (out_o.color_count),
  .out_error_i (out_o.error),
  .out_last_i  (out_o.last)
);

`default_nettype wire

// ----- tb/tb_greedy_graph_coloring.sv -----
// Self-checking testbench for greedy_graph_coloring: loads edges, runs both orderings,
// predicts every result word and compares it with what the block emits.
// Depends on ggc_pkg, ggc_if and the greedy_graph_coloring RTL.
`timescale 1ns / 100ps

module tb_greedy_graph_coloring;
  import ggc_pkg::*;

  localparam int NODES      = 64;
  localparam int EDGES      = 256;
  localparam int NO_MARK    = 127;  // uncolored / visited / no slot
  localparam int CYCLE_MAX  = 3000000;
  localparam int DRAIN_WAIT = 60;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] color_count;
    logic               error;
    logic               last;
  } coloring_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ggc_in_if  in_if ();
  ggc_out_if out_if ();
  ggc_cfg_if cfg_if ();

  greedy_graph_coloring dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [NODE_W-1:0] ea [EDGES];
  logic [NODE_W-1:0] eb [EDGES];
  int        edge_cnt;
  bit        overflowed;
  logic      mode_q;
  int        ncount_q;
  int        wt [NODES];
  int        slot [NODES];
  int        bslot [NODES][NODES];
  int        bfill [NODES];
  int        topw;
  int        order [NODES];
  int        col [NODES];
  coloring_t expected_q[$];

  // run control
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  int  items_sent = 0;
  int  runs_done = 0;
  int  err_runs = 0;
  int  words_seen = 0;
  int  mismatches = 0;
  int  cycles = 0;

  function automatic int other_end(int k, int v);
    if (ea[k] == v) return eb[k];
    if (eb[k] == v) return ea[k];
    return -1;
  endfunction

  function automatic void bucket_put(int w, int v);
    slot[v] = bfill[w];
    wt[v] = w;
    bslot[w][bfill[w] % NODES] = v;
    bfill[w]++;
    if (topw < w) topw = w;
  endfunction

  function automatic int bucket_take();
    int t, v, f, lv, nt, b;
    t = topw;
    v = bslot[t][0];
    f = bfill[t];
    slot[v] = NO_MARK;
    if (f > 1) begin
      lv = bslot[t][f-1];
      slot[lv] = 0;
      bslot[t][0] = lv;
    end
    bfill[t] = f - 1;
    wt[v] = NO_MARK;
    if (bfill[t] == 0) begin
      nt = 0;
      b = t;
      while (b > 0) begin
        b--;
        if (bfill[b] != 0) begin
          nt = b;
          break;
        end
      end
      topw = nt;
    end
    return v;
  endfunction

  function automatic void bucket_bump(int v);
    int w, i, f, lv;
    w = wt[v];
    i = slot[v];
    f = bfill[w];
    if (w + 1 >= NODES || f == 0 || i >= f) return;
    lv = bslot[w][f-1];
    slot[lv] = i;
    bslot[w][i] = lv;
    bfill[w] = f - 1;
    bucket_put(w + 1, v);
  endfunction

  function automatic void order_by_search(int n);
    int u, v;
    for (int i = 0; i < NODES; i++) begin
      wt[i] = 0;
      slot[i] = NO_MARK;
      bfill[i] = 0;
    end
    topw = 0;
    bucket_put(0, 0);
    for (int it = 0; it < n; it++) begin
      if (bfill[topw] == 0) begin
        u = 0;
        while (u < n && wt[u] == NO_MARK) u++;
        if (u >= n) break;
        topw = 0;
        bucket_put(0, u);
      end
      v = bucket_take();
      order[it] = v;
      for (int k = 0; k < edge_cnt; k++) begin
        u = other_end(k, v);
        if (u < 0 || wt[u] == NO_MARK) continue;
        if (wt[u] == 0) bucket_put(1, u);
        else bucket_bump(u);
      end
    end
  endfunction

  function automatic void order_by_degree(int n);
    int  deg [NODES];
    bit  taken [NODES];
    int  best;
    bit  found;
    for (int v = 0; v < NODES; v++) begin
      deg[v] = 0;
      taken[v] = 0;
    end
    for (int k = 0; k < edge_cnt; k++) begin
      deg[ea[k]]++;
      deg[eb[k]]++;
    end
    for (int i = 0; i < n; i++) begin
      best = 0;
      found = 0;
      for (int v = 0; v < n; v++) begin
        if (taken[v]) continue;
        if (!found || deg[v] > deg[best]) begin
          best = v;
          found = 1;
        end
      end
      taken[best] = 1;
      order[i] = best;
    end
  endfunction

  // applies one accepted input word to the predictor
  function automatic void predict_word(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int n, v, u, c, count;
    bit bad;
    bit used [NODES];
    coloring_t r;
    if (op == OP_LOAD) begin
      if (edge_cnt >= EDGES) overflowed = 1;
      else begin
        ea[edge_cnt] = a;
        eb[edge_cnt] = b;
        edge_cnt++;
      end
      return;
    end
    n = ncount_q;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    bad = overflowed;
    for (int k = 0; k < edge_cnt; k++)
      if (ea[k] >= n || eb[k] >= n) bad = 1;
    runs_done++;
    if (bad) begin
      err_runs++;
      r = '0;
      r.error = 1'b1;
      r.last = 1'b1;
      expected_q = {expected_q, r};
    end else begin
      if (mode_q == MODE_MCS) order_by_search(n);
      else order_by_degree(n);
      for (int i = 0; i < NODES; i++) col[i] = NO_MARK;
      count = 0;
      for (int i = 0; i < n; i++) begin
        v = order[i];
        for (int j = 0; j < NODES; j++) used[j] = 0;
        for (int k = 0; k < edge_cnt; k++) begin
          u = other_end(k, v);
          if (u >= 0 && col[u] != NO_MARK) used[col[u]] = 1;
        end
        c = 0;
        while (c < NODES - 1 && used[c]) c++;
        col[v] = c;
        if (c + 1 > count) count = c + 1;
      end
      for (int i = 0; i < n; i++) begin
        r.node = NODE_W'(i);
        r.color = (col[i] == NO_MARK) ? '0 : COLOR_W'(col[i]);
        r.color_count = COUNT_W'(count);
        r.error = 1'b0;
        r.last = (i + 1 == n);
        expected_q = {expected_q, r};
      end
    end
    edge_cnt = 0;
    overflowed = 0;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.end_a = a;
    in_if.end_b = b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(op, a, b);
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic load_edge(int a, int b);
    send_word(OP_LOAD, a[NODE_W-1:0], b[NODE_W-1:0]);
  endtask

  task automatic run_coloring();
    send_word(OP_RUN, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_ORDER_MODE) mode_q = value[0];
    else ncount_q = value & 8'h7f;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic setup(logic mode, int cnt);
    drain();
    write_reg(REG_ORDER_MODE, mode);
    write_reg(REG_NODE_COUNT, cnt);
  endtask

  // random graph on n nodes; bad_pct % of edges get end b in n..63, outside if n < 64
  task automatic random_graph(int n, int e, int bad_pct);
    int a, b;
    for (int i = 0; i < e; i++) begin
      a = $urandom_range(n - 1);
      b = ($urandom_range(9) == 0) ? a : $urandom_range(n - 1);
      if ($urandom_range(99) < bad_pct) b = $urandom_range(63, n < 64 ? n : 63);
      load_edge(a, b);
    end
    run_coloring();
  endtask

  // receiver side: ready changes at the falling edge
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    coloring_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.node, out_if.color, out_if.color_count, out_if.error, out_if.last};
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.node !== want.node || got.color !== want.color ||
            got.color_count !== want.color_count || got.error !== want.error ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    setup(MODE_MCS, 64);
    load_edge(0, 63);
    load_edge(63, 63);   // self loop
    load_edge(5, 0);
    load_edge(5, 63);
    load_edge(5, 0);     // repeated edge
    load_edge(42, 21);
    run_coloring();
    setup(MODE_DEGREE, 64);
    load_edge(63, 0);
    load_edge(7, 7);
    load_edge(1, 2);
    load_edge(2, 3);
    load_edge(3, 1);
    load_edge(1, 2);
    run_coloring();
    run_coloring();      // no edges at all
    setup(MODE_MCS, 0);  // acts as a single node
    run_coloring();
    setup(MODE_MCS, 127);
    load_edge(10, 11);
    run_coloring();
    setup(MODE_DEGREE, 4);
    load_edge(0, 3);
    load_edge(1, 4);     // endpoint out of range
    run_coloring();
    setup(MODE_MCS, 1);
    load_edge(0, 0);
    run_coloring();
  endtask

  task automatic test_store_overflow();
    setup(MODE_MCS, 8);
    for (int i = 0; i <= EDGES; i++) load_edge($urandom_range(7), $urandom_range(7));
    run_coloring();
  endtask

  task automatic test_backpressure();
    setup(MODE_DEGREE, 16);
    hold_left = 600;
    random_graph(16, 12, 0);
    random_graph(16, 8, 0);
    random_graph(16, 5, 0);
  endtask

  task automatic test_random(int goal);
    int n;
    while (items_sent < goal) begin
      n = ($urandom_range(19) == 0) ? 64 : $urandom_range(2, 12);
      setup(1'($urandom_range(1)), $urandom_range(9) == 0 ? $urandom_range(65, 127) : n);
      if (ncount_q > 64) n = 64;
      random_graph(n, $urandom_range(0, n == 64 ? 40 : 3 * n), $urandom_range(3) == 0 ? 10 : 0);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.end_a = '0;
    in_if.end_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ORDER_MODE;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    edge_cnt = 0;
    overflowed = 0;
    mode_q = MODE_MCS;
    ncount_q = 64;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_store_overflow();
    test_backpressure();
    send_idle_pct = 0;   stall_pct = 0;  test_random(items_sent + 15);
    send_idle_pct = 74;  stall_pct = 0;  test_random(items_sent + 15);
    send_idle_pct = 0;   stall_pct = 74; test_random(items_sent + 15);
    send_idle_pct = 33;  stall_pct = 33; test_random(items_sent + 15);
    drain();

    $display("sent %0d words, %0d runs (%0d with a bad edge store), checked %0d results",
             items_sent, runs_done, err_runs, words_seen);
    $display("both orderings, node counts 1 to 64, store overflow and output backpressure");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ggc_pkg.sv
hw/rtl/ggc_if.sv
hw/rtl/ggc_ram.sv
hw/rtl/greedy_graph_coloring.sv
hw/rtl/ggc_checker.sv
tb/tb_greedy_graph_coloring.sv
